/* hw/rtl/fba_pkg.sv */
`default_nettype none
package fba_pkg;

  localparam int MAP_WORDS = 1024;
  localparam int WORD_AW   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int FRAME_W   = 20;
  localparam int MAP_W     = 32;

  localparam logic [FRAME_W-1:0] OFFSET_RESET = FRAME_W'(512);
  localparam logic [MAP_W-1:0]   ALL_ONES     = '1;

  typedef enum logic [1:0] {
    FN_ALLOC   = 2'd0,
    FN_RELEASE = 2'd1,
    FN_MARK    = 2'd2,
    FN_CLEAR   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_NOFREE = 2'd1,
    STAT_RANGE  = 2'd2
  } status_t;

  // position of the lowest clear bit; 31 when bits 0..30 are all set
  function automatic logic [4:0] lowest_zero(input logic [MAP_W-1:0] word);
    logic [4:0] pos;
    pos = 5'd31;
    for (int i = MAP_W - 1; i >= 0; i--) begin
      if (!word[i]) begin
        pos = 5'(i);
      end
    end
    return pos;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/fba_req_if.sv */
`default_nettype none
interface fba_req_if import fba_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic [FRAME_W-1:0] frame_num;
  logic [FRAME_W-1:0] frame_count;

  modport source (output valid, func, frame_num, frame_count, input ready);
  modport sink   (input valid, func, frame_num, frame_count, output ready);
endinterface
`default_nettype wire

/* hw/rtl/fba_rsp_if.sv */
`default_nettype none
interface fba_rsp_if import fba_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FRAME_W-1:0] allocated_frame;
  logic [1:0]         status;

  modport source (output valid, allocated_frame, status, input ready);
  modport sink   (input valid, allocated_frame, status, output ready);
endinterface
`default_nettype wire

/* hw/rtl/fba_ram.sv */
`default_nettype none
module fba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* hw/rtl/frame_bitmap_allocator_unit.sv */
`default_nettype none
// Bitmap page-frame allocator, one request at a time. After reset the map is
// cleared by a pass over all MAP_WORDS (1024) words before the first item is
// taken; a clear request runs the same pass. An item is read in S_IDLE and its
// word span worked out through S_REL, S_SPAN and S_DECIDE; allocate then streams
// one bitmap word per cycle through the single RAM read port (first-fit), mark
// writes one word per cycle, and release does a read-modify-write. The result
// waits in an output register until taken, and the next item is accepted once
// it has gone.
module frame_bitmap_allocator_unit import fba_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               frame_offset_we,
  input  wire logic [FRAME_W-1:0] frame_offset_wdata,
  fba_req_if.sink                 req,
  fba_rsp_if.source               rsp
);

  typedef enum logic [8:0] {
    S_CLEAR  = 9'b000000001,
    S_IDLE   = 9'b000000010,
    S_REL    = 9'b000000100,
    S_SPAN   = 9'b000001000,
    S_DECIDE = 9'b000010000,
    S_SCAN   = 9'b000100000,
    S_MARK   = 9'b001000000,
    S_RMW    = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_t;

  state_t state;

  logic [FRAME_W-1:0] frame_offset;
  func_t              func_r;
  logic [FRAME_W-1:0] num_r;
  logic [FRAME_W-1:0] cnt_r;
  logic [FRAME_W-1:0] rel;
  logic               below;
  logic [FRAME_W:0]   end_sum;
  logic [WORD_AW:0]   first_w;
  logic [WORD_AW:0]   last_w;
  logic [WORD_AW:0]   scan_w;
  logic [WORD_AW:0]   chk_w;
  logic               chk_vld;
  logic [WORD_AW-1:0] clr_w;
  logic               clr_op;
  logic [FRAME_W-1:0] granted;
  status_t            status;

  logic               ram_we;
  logic [WORD_AW-1:0] ram_waddr;
  logic [MAP_W-1:0]   ram_wdata;
  logic [WORD_AW-1:0] ram_raddr;
  logic [MAP_W-1:0]   ram_rdata;

  logic [4:0]         free_bit;
  logic [14:0]        rel_word;
  logic [15:0]        last16;
  logic [FRAME_W+1:0] top_frame;
  logic               span_bad;
  logic [FRAME_W-1:0] grant_calc;

  fba_ram #(.WIDTH(MAP_W), .DEPTH(MAP_WORDS)) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign free_bit   = lowest_zero(ram_rdata);
  assign rel_word   = rel[FRAME_W-1:5];
  assign last16     = end_sum[FRAME_W:5];
  assign top_frame  = {2'b00, frame_offset} + {1'b0, last16, 5'b00000};
  assign span_bad   = below || ({1'b0, last16} > 17'(MAP_WORDS)) ||
                      ((func_r == FN_ALLOC) && (top_frame > (FRAME_W+2)'(1 << FRAME_W)));
  assign grant_calc = frame_offset + FRAME_W'({chk_w[WORD_AW-1:0], free_bit});

  assign req.ready           = (state == S_IDLE);
  assign rsp.valid           = (state == S_DONE);
  assign rsp.allocated_frame = granted;
  assign rsp.status          = status;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_w;
    ram_wdata = '0;
    ram_raddr = rel_word[WORD_AW-1:0];
    unique case (state)
      S_CLEAR: begin
        ram_we = 1'b1;
      end
      S_SCAN: begin
        ram_raddr = scan_w[WORD_AW-1:0];
        ram_waddr = chk_w[WORD_AW-1:0];
        ram_wdata = ram_rdata | (MAP_W'(1) << free_bit);
        ram_we    = chk_vld && (ram_rdata != ALL_ONES);
      end
      S_MARK: begin
        ram_we    = 1'b1;
        ram_waddr = scan_w[WORD_AW-1:0];
        ram_wdata = ALL_ONES;
      end
      S_RMW: begin
        ram_we    = 1'b1;
        ram_waddr = rel_word[WORD_AW-1:0];
        ram_wdata = ram_rdata & ~(MAP_W'(1) << rel[4:0]);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_offset <= OFFSET_RESET;
    end else if (frame_offset_we) begin
      frame_offset <= frame_offset_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_w   <= '0;
      clr_op  <= 1'b0;
      chk_vld <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          // wraps back to zero on the last word
          clr_w <= clr_w + 1'b1;
          if (clr_w == WORD_AW'(MAP_WORDS - 1)) begin
            granted <= '0;
            status  <= STAT_OK;
            state   <= clr_op ? S_DONE : S_IDLE;
          end
        end
        S_IDLE: begin
          if (req.valid) begin
            func_r <= func_t'(req.func);
            num_r  <= req.frame_num;
            cnt_r  <= req.frame_count;
            if (func_t'(req.func) == FN_CLEAR) begin
              clr_op <= 1'b1;
              state  <= S_CLEAR;
            end else begin
              state <= S_REL;
            end
          end
        end
        S_REL: begin
          below <= num_r < frame_offset;
          rel   <= num_r - frame_offset;
          state <= S_SPAN;
        end
        S_SPAN: begin
          granted <= '0;
          if (func_r == FN_RELEASE) begin
            // word read issued this cycle when in range
            if (below || ({2'b00, rel_word} >= 17'(MAP_WORDS))) begin
              status <= STAT_RANGE;
              state  <= S_DONE;
            end else begin
              status <= STAT_OK;
              state  <= S_RMW;
            end
          end else begin
            end_sum <= {1'b0, rel} + {1'b0, cnt_r};
            state   <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (span_bad) begin
            status <= STAT_RANGE;
            state  <= S_DONE;
          end else if (last16 <= {1'b0, rel_word}) begin
            status <= (func_r == FN_ALLOC) ? STAT_NOFREE : STAT_OK;
            state  <= S_DONE;
          end else begin
            first_w <= rel_word[WORD_AW:0];
            last_w  <= last16[WORD_AW:0];
            scan_w  <= rel_word[WORD_AW:0];
            chk_vld <= 1'b0;
            state   <= (func_r == FN_ALLOC) ? S_SCAN : S_MARK;
          end
        end
        S_SCAN: begin
          // read of scan_w issued now, data of chk_w checked now
          if (chk_vld && (ram_rdata != ALL_ONES)) begin
            granted <= grant_calc;
            status  <= STAT_OK;
            chk_vld <= 1'b0;
            state   <= S_DONE;
          end else if (chk_vld && ((chk_w + 1'b1) == last_w)) begin
            status  <= STAT_NOFREE;
            chk_vld <= 1'b0;
            state   <= S_DONE;
          end else begin
            chk_vld <= (scan_w < last_w) && (scan_w >= first_w);
            chk_w   <= scan_w;
            scan_w  <= scan_w + 1'b1;
          end
        end
        S_MARK: begin
          scan_w <= scan_w + 1'b1;
          if ((scan_w + 1'b1) == last_w) begin
            status <= STAT_OK;
            state  <= S_DONE;
          end
        end
        S_RMW: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (rsp.ready) begin
            clr_op <= 1'b0;
            state  <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

/* verif/tb_top.sv */
`default_nettype none
module tb_top;
  import fba_pkg::*;

  typedef struct {
    func_t              func;
    logic [FRAME_W-1:0] num;
    logic [FRAME_W-1:0] cnt;
  } frame_req_t;

  typedef struct {
    logic [FRAME_W-1:0] frame;
    status_t            status;
  } grant_t;

  localparam int unsigned MAP_FRAMES = MAP_WORDS * MAP_W;

  logic clk;
  logic rst;
  logic ofs_we;
  logic [FRAME_W-1:0] ofs_wdata;

  fba_req_if req_if ();
  fba_rsp_if rsp_if ();

  frame_bitmap_allocator_unit DUT (
    .clk                (clk),
    .rst                (rst),
    .frame_offset_we    (ofs_we),
    .frame_offset_wdata (ofs_wdata),
    .req                (req_if),
    .rsp                (rsp_if)
  );

  // shadow of the allocator state
  logic [MAP_W-1:0]   shadow_map [MAP_WORDS];
  logic [FRAME_W-1:0] base_frame;

  frame_req_t pending_requests[$];
  grant_t     expected_grants[$];

  int  mismatches = 0;
  int  n_requests = 0;
  int  n_granted  = 0;
  int  n_nofree   = 0;
  int  n_range    = 0;
  int  n_offsets  = 0;
  int  req_gap    = 0;
  int  rsp_stall  = 0;
  bit  burst_mode = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatches++;
  endtask

  function automatic int pick_gap();
    int r;
    if (burst_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    else if (r < 85) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 12);
    else return $urandom_range(20, 80);
  endfunction

  // first-fit allocator behavior, updates the shadow map
  function automatic grant_t apply_request(input frame_req_t it);
    grant_t g;
    longint unsigned rel, first_w, last_w, w;
    int b;
    bit in_pool, found;
    g.frame  = '0;
    g.status = STAT_OK;
    in_pool  = it.num >= base_frame;
    rel      = in_pool ? (longint'(it.num) - longint'(base_frame)) : 0;
    first_w  = rel / MAP_W;
    last_w   = (rel + longint'(it.cnt)) / MAP_W;
    found    = 0;
    case (it.func)
      FN_ALLOC: begin
        if (!in_pool || last_w > MAP_WORDS ||
            longint'(base_frame) + last_w * MAP_W > (longint'(1) << FRAME_W)) begin
          g.status = STAT_RANGE;
        end else begin
          g.status = STAT_NOFREE;
          for (w = first_w; w < last_w && !found; w++) begin
            if (shadow_map[w] != ALL_ONES) begin
              b = 0;
              while (b < MAP_W - 1 && shadow_map[w][b]) b++;
              shadow_map[w][b] = 1'b1;
              g.frame  = FRAME_W'(longint'(base_frame) + w * MAP_W + b);
              g.status = STAT_OK;
              found    = 1;
            end
          end
        end
      end
      FN_RELEASE: begin
        if (!in_pool || first_w >= MAP_WORDS) g.status = STAT_RANGE;
        else shadow_map[first_w][rel[4:0]] = 1'b0;
      end
      FN_MARK: begin
        if (!in_pool || last_w > MAP_WORDS) begin
          g.status = STAT_RANGE;
        end else begin
          for (w = first_w; w < last_w; w++) shadow_map[w] = ALL_ONES;
        end
      end
      default: begin
        foreach (shadow_map[i]) shadow_map[i] = '0;
      end
    endcase
    return g;
  endfunction

  // request side
  always @(posedge clk) begin
    bit send;
    grant_t g;
    if (rst) begin
      req_if.valid <= 1'b0;
      req_gap = 0;
      foreach (shadow_map[i]) shadow_map[i] = '0;
    end else begin
      send = req_if.valid;
      if (req_if.valid && req_if.ready) begin
        g = apply_request(pending_requests.pop_front());
        expected_grants.push_back(g);
        n_requests++;
        case (g.status)
          STAT_OK:     n_granted++;
          STAT_NOFREE: n_nofree++;
          default:     n_range++;
        endcase
        req_gap = pick_gap();
        send = 0;
      end
      if (!send) begin
        if (req_gap > 0) req_gap--;
        else send = pending_requests.size() > 0;
      end
      req_if.valid <= send;
      if (send) begin
        req_if.func        <= pending_requests[0].func;
        req_if.frame_num   <= pending_requests[0].num;
        req_if.frame_count <= pending_requests[0].cnt;
      end
    end
  end

  // result side
  always @(posedge clk) begin
    grant_t exp_g;
    if (rst) begin
      rsp_if.ready <= 1'b0;
      rsp_stall = 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_grants.size() == 0) begin
          report_mismatch($sformatf("unexpected result frame=%0h status=%0d",
                                    rsp_if.allocated_frame, rsp_if.status));
        end else begin
          exp_g = expected_grants.pop_front();
          if (rsp_if.allocated_frame !== exp_g.frame)
            report_mismatch($sformatf("allocated_frame %0h, expected %0h",
                                      rsp_if.allocated_frame, exp_g.frame));
          if (rsp_if.status !== exp_g.status)
            report_mismatch($sformatf("status %0d, expected %0d",
                                      rsp_if.status, exp_g.status));
        end
        rsp_stall = pick_gap();
      end
      if (rsp_stall > 0) begin
        rsp_stall--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  task automatic add_req(input func_t f, input logic [FRAME_W-1:0] num,
                         input logic [FRAME_W-1:0] cnt);
    frame_req_t it;
    it.func = f;
    it.num  = num;
    it.cnt  = cnt;
    pending_requests.push_back(it);
  endtask

  task automatic wait_drained();
    while (pending_requests.size() != 0 || req_if.valid || expected_grants.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_offset(input logic [FRAME_W-1:0] v);
    repeat (4) @(posedge clk);
    ofs_we    <= 1'b1;
    ofs_wdata <= v;
    base_frame = v;
    n_offsets++;
    @(posedge clk);
    ofs_we <= 1'b0;
  endtask

  // mostly traffic inside a small hot region so the map fills and drains
  function automatic frame_req_t make_req(input int unsigned hot_words);
    frame_req_t it;
    int r;
    int unsigned span;
    span    = hot_words * MAP_W;
    r       = $urandom_range(0, 99);
    it.func = FN_ALLOC;
    it.num  = FRAME_W'(base_frame + $urandom_range(0, span - 1));
    it.cnt  = FRAME_W'($urandom_range(0, span + MAP_W));
    if (r < 40) begin
      it.func = FN_ALLOC;
    end else if (r < 60) begin
      it.func = FN_RELEASE;
    end else if (r < 70) begin
      it.func = FN_MARK;
      it.cnt  = FRAME_W'($urandom_range(0, 3 * MAP_W));
    end else if (r < 74) begin
      // scan across the whole map
      it.num = base_frame;
      it.cnt = FRAME_W'(MAP_FRAMES);
    end else if (r < 76) begin
      it.func = FN_CLEAR;
    end else if (r < 90) begin
      it.func = func_t'($urandom_range(0, 2));
      it.num  = FRAME_W'($urandom);
      it.cnt  = FRAME_W'($urandom);
    end else begin
      // just below the low end or around the high end of the bitmap
      it.func = func_t'($urandom_range(0, 2));
      if ($urandom_range(0, 1))
        it.num = FRAME_W'(base_frame - $urandom_range(1, 4));
      else
        it.num = FRAME_W'(base_frame + MAP_FRAMES - 8 + $urandom_range(0, 16));
      it.cnt = FRAME_W'($urandom_range(0, 64));
    end
    return it;
  endfunction

  initial begin
    logic [FRAME_W-1:0] offsets [6];
    int unsigned hot, chunk, n;
    rst        = 1'b1;
    ofs_we     = 1'b0;
    ofs_wdata  = '0;
    base_frame = OFFSET_RESET;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed part at the reset offset
    add_req(FN_ALLOC,   20'd512, 20'd32);
    add_req(FN_ALLOC,   20'd512, 20'd32);
    add_req(FN_RELEASE, 20'd512, 20'd0);
    add_req(FN_RELEASE, 20'd512, 20'd0);          // already free
    add_req(FN_ALLOC,   20'd511, 20'd32);         // below offset
    add_req(FN_RELEASE, 20'd511, 20'd0);
    add_req(FN_MARK,    20'd0,   20'd64);
    add_req(FN_ALLOC,   20'd512, 20'd0);          // empty span
    add_req(FN_MARK,    20'd512, 20'd5);
    add_req(FN_MARK,    20'd544, 20'd64);
    add_req(FN_ALLOC,   20'd544, 20'd96);
    add_req(FN_ALLOC,   20'd544, 20'd64);         // both words full
    add_req(FN_RELEASE, FRAME_W'(512 + MAP_FRAMES), 20'd0);
    add_req(FN_RELEASE, FRAME_W'(511 + MAP_FRAMES), 20'd0);
    add_req(FN_ALLOC,   20'd512, FRAME_W'(MAP_FRAMES + 32));
    add_req(FN_ALLOC,   20'd512, FRAME_W'(MAP_FRAMES));
    add_req(FN_MARK,    20'd512, FRAME_W'(MAP_FRAMES));
    add_req(FN_ALLOC,   20'd512, FRAME_W'(MAP_FRAMES));   // nothing free anywhere
    add_req(FN_RELEASE, 20'd543, 20'd0);
    add_req(FN_ALLOC,   20'd512, 20'd32);         // only bit 31 free
    add_req(FN_MARK,    FRAME_W'(512 + MAP_FRAMES - 32), 20'd64);
    add_req(FN_CLEAR,   20'hFFFFF, 20'hFFFFF);
    add_req(FN_ALLOC,   20'hFFFFF, 20'hFFFFF);
    add_req(FN_RELEASE, 20'hFFFFF, 20'd0);
    add_req(FN_ALLOC,   20'd679, 20'd32);         // grant lies below the requested frame
    wait_drained();

    offsets[0] = '0;
    offsets[1] = 20'hFFFFF;
    offsets[2] = FRAME_W'(20'hFFFFF - MAP_FRAMES + $urandom_range(0, 2000));
    offsets[3] = FRAME_W'($urandom);
    offsets[4] = OFFSET_RESET;
    offsets[5] = FRAME_W'($urandom_range(0, 4000));

    foreach (offsets[p]) begin
      write_offset(offsets[p]);
      if (p == 1) begin
        add_req(FN_RELEASE, 20'hFFFFF, 20'd0);
        add_req(FN_ALLOC,   20'hFFFFF, 20'd32);    // map end beyond 20 bits
        add_req(FN_MARK,    20'hFFFFF, 20'hFFFFF);
      end
      hot = $urandom_range(1, 48);
      n   = 0;
      while (n < 135) begin
        chunk      = $urandom_range(15, 50);
        burst_mode = ($urandom_range(0, 3) == 0);
        repeat (chunk) pending_requests.push_back(make_req(hot));
        n += chunk;
        while (pending_requests.size() != 0) @(posedge clk);
        if ($urandom_range(0, 2) == 0) wait_drained();
      end
      burst_mode = 0;
      wait_drained();
    end

    repeat (20) @(posedge clk);
    $display("Ran %0d requests under %0d offset settings beyond reset.",
             n_requests, n_offsets);
    $display("Outcomes: %0d done, %0d no free frame, %0d out of range.",
             n_granted, n_nofree, n_range);
    if (mismatches == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
`default_nettype wire
